>>> rtl/core/srr_pkg.sv
package srr_pkg;

    // Default configuration
    localparam int SEQ_BITS_DEF     = 3;
    localparam int WINDOW_DEF       = 4;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Packet queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    // Result kinds
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    // Back-end status seen by the top level
    typedef struct packed {
        logic in_deliver;
        logic base_received;
    } t_back_status;

endpackage

>>> rtl/core/srr_front.sv
module srr_front #(
    parameter int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [SEQ_BITS-1:0]     i_seq_number,
    input  logic                    i_checksum_ok,
    input  logic [PAYLOAD_BITS-1:0] i_payload_word,
    output logic                    o_q_valid,
    input  logic                    i_q_pop,
    output logic [SEQ_BITS-1:0]     o_q_seq,
    output logic [PAYLOAD_BITS-1:0] o_q_pay
);

    logic [SEQ_BITS-1:0]            r_q_seq [srr_pkg::Q_DEPTH];
    logic [PAYLOAD_BITS-1:0]        r_q_pay [srr_pkg::Q_DEPTH];
    logic [srr_pkg::Q_AW-1:0]       r_wp, n_wp;
    logic [srr_pkg::Q_AW-1:0]       r_rp, n_rp;
    logic [srr_pkg::Q_CW-1:0]       r_cnt, n_cnt;
    logic                           enq;
    logic                           deq;

    // Corrupt packets are consumed here and never reach the window logic
    assign full      = (r_cnt == srr_pkg::Q_CW'(srr_pkg::Q_DEPTH));
    assign enq       = push && !full && i_checksum_ok;
    assign deq       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_seq   = r_q_seq[r_rp];
    assign o_q_pay   = r_q_pay[r_rp];

    // Pointer and fill count update
    always_comb begin
        n_wp  = enq ? r_wp + 1'b1 : r_wp;
        n_rp  = deq ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (enq && !deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (deq && !enq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q_seq[r_wp] <= i_seq_number;
            r_q_pay[r_wp] <= i_payload_word;
        end
    end

endmodule

>>> rtl/core/srr_back.sv
module srr_back #(
    parameter int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF,
    parameter int WINDOW       = srr_pkg::WINDOW_DEF,
    parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    output logic                    o_q_pop,
    input  logic [SEQ_BITS-1:0]     i_q_seq,
    input  logic [PAYLOAD_BITS-1:0] i_q_pay,
    input  logic                    i_out_pop,
    output logic                    o_out_valid,
    output logic                    o_kind,
    output logic [SEQ_BITS-1:0]     o_num,
    output logic [PAYLOAD_BITS-1:0] o_data,
    output logic                    o_last,
    output srr_pkg::t_back_status   o_status
);

    localparam int RING  = 1 << SEQ_BITS;
    localparam int LIMIT = (WINDOW < RING) ? WINDOW : RING;
    localparam int CNT_W = $clog2(LIMIT + 1);
    localparam logic [CNT_W-1:0] LIMIT_M1 = CNT_W'(LIMIT - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_DELIV = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [SEQ_BITS-1:0]     r_base, n_base;
    logic [RING-1:0]         r_rcv, n_rcv;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [PAYLOAD_BITS-1:0] r_mem [RING];
    logic [PAYLOAD_BITS-1:0] r_rd_data;
    logic [SEQ_BITS-1:0]     rd_addr;
    logic                    we;

    logic                    r_out_valid;
    logic                    r_out_kind, n_out_kind;
    logic [SEQ_BITS-1:0]     r_out_num, n_out_num;
    logic [PAYLOAD_BITS-1:0] r_out_data, n_out_data;
    logic                    r_out_last, n_out_last;
    logic                    out_load;
    logic                    out_free;

    logic [SEQ_BITS-1:0]     ahead;
    logic [SEQ_BITS-1:0]     behind;
    logic                    in_win;
    logic                    in_prev;
    logic                    fire;
    logic                    more;
    logic [SEQ_BITS-1:0]     base_nx;

    // Window classification against the current base
    assign ahead   = i_q_seq - r_base;
    assign behind  = r_base - i_q_seq;
    assign in_win  = (32'(ahead) < 32'(WINDOW));
    assign in_prev = (behind != '0) && (32'(behind) <= 32'(WINDOW));

    assign out_free = !r_out_valid || i_out_pop;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && out_free;
    assign base_nx  = r_base + 1'b1;
    assign fire     = (r_state == S_DELIV) && out_free;
    assign more     = (r_cnt < LIMIT_M1) && r_rcv[base_nx];
    assign we       = o_q_pop && in_win;
    assign rd_addr  = fire ? base_nx : r_base;

    // Sequencer: acknowledge, then drain consecutive slots from the base once the base slot arrives
    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_rcv      = r_rcv;
        n_cnt      = r_cnt;
        out_load   = 1'b0;
        n_out_kind = r_out_kind;
        n_out_num  = r_out_num;
        n_out_data = r_out_data;
        n_out_last = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop && (in_win || in_prev)) begin
                    out_load   = 1'b1;
                    n_out_kind = srr_pkg::KIND_ACK;
                    n_out_num  = i_q_seq;
                    n_out_data = i_q_pay;
                    n_out_last = 1'b1;
                    if (in_win) begin
                        n_rcv[i_q_seq] = 1'b1;
                        if (i_q_seq == r_base) begin
                            n_out_last = 1'b0;
                            n_cnt      = '0;
                            n_state    = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_DELIV;
            end
            S_DELIV: begin
                if (fire) begin
                    out_load      = 1'b1;
                    n_out_kind    = srr_pkg::KIND_DELIVER;
                    n_out_num     = r_base;
                    n_out_data    = r_rd_data;
                    n_out_last    = !more;
                    n_rcv[r_base] = 1'b0;
                    n_base        = base_nx;
                    n_cnt         = r_cnt + 1'b1;
                    if (!more) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_rcv       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_rcv       <= n_rcv;
            r_cnt       <= n_cnt;
            r_out_valid <= out_load || (r_out_valid && !i_out_pop);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_num  <= n_out_num;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // Slot payload memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[i_q_seq] <= i_q_pay;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_num       = r_out_num;
    assign o_data      = r_out_data;
    assign o_last      = r_out_last;

    assign o_status.in_deliver    = (r_state == S_DELIV);
    assign o_status.base_received = r_rcv[r_base];

endmodule

>>> rtl/core/selective_repeat_receiver_core.sv
// An acknowledgement passes the packet queue and then the result register to the ports.
// Throughput: the single back-end sequencer handles one packet at a time; a packet
// that is dropped, re-acknowledged or buffered out of order needs only that pass, while
// one at the window base also releases its run of slots, one result per cycle while the
// result register is free, after the S_READ state for the registered slot-memory read.
// Reset: synchronous, active low; clears the window base, received flags and queues.
module selective_repeat_receiver_core #(
    parameter int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF,
    parameter int WINDOW       = srr_pkg::WINDOW_DEF,
    parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [SEQ_BITS-1:0]     i_seq_number,
    input  logic                    i_checksum_ok,
    input  logic [PAYLOAD_BITS-1:0] i_payload_word,
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_result_kind,
    output logic [SEQ_BITS-1:0]     o_ack_number,
    output logic [PAYLOAD_BITS-1:0] o_data_word,
    output logic                    o_last
);

    logic                    q_valid;
    logic                    q_pop;
    logic [SEQ_BITS-1:0]     q_seq;
    logic [PAYLOAD_BITS-1:0] q_pay;
    logic                    out_valid;
    srr_pkg::t_back_status   status;

    // Packet intake and filtering
    srr_front #(
        .SEQ_BITS     (SEQ_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_seq_number   (i_seq_number),
        .i_checksum_ok  (i_checksum_ok),
        .i_payload_word (i_payload_word),
        .o_q_valid      (q_valid),
        .i_q_pop        (q_pop),
        .o_q_seq        (q_seq),
        .o_q_pay        (q_pay)
    );

    // Window logic and result generation
    srr_back #(
        .SEQ_BITS     (SEQ_BITS),
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_seq     (q_seq),
        .i_q_pay     (q_pay),
        .i_out_pop   (pop),
        .o_out_valid (out_valid),
        .o_kind      (o_result_kind),
        .o_num       (o_ack_number),
        .o_data      (o_data_word),
        .o_last      (o_last),
        .o_status    (status)
    );

    assign empty = !out_valid;

    // Delivery only runs while the slot at the base holds a payload
    a_deliver_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.in_deliver |-> status.base_received)
        else $error("delivery with base slot not received");

    // A packet leaves the queue only when the result register can take its ack
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_valid) |-> (empty || pop))
        else $error("queue popped with result register blocked");

    // No packet is taken from the queue while a delivery run is in progress
    a_no_pop_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.in_deliver |-> !q_pop)
        else $error("queue popped during delivery");

    // After reset both sides are idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not idle after reset");

endmodule
